// ----- sv/command_byte_stream_decoder_defines.svh -----
// Assertion macros shared by the command byte stream decoder.
`ifndef COMMAND_BYTE_STREAM_DECODER_DEFINES_SVH
`define COMMAND_BYTE_STREAM_DECODER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define CBSD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define CBSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cbsd_pkg.sv -----
// Package with types and constants of the command byte stream decoder.
`default_nettype none

package cbsd_pkg;

    localparam int ROW_PIXELS = 320;
    localparam int COL_W      = 9;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(ROW_PIXELS - 1);

    localparam logic [7:0] OP_BUTTON  = 8'd1;
    localparam logic [7:0] OP_SCREEN  = 8'd16;
    localparam logic [7:0] OP_CONSOLE = 8'd21;
    localparam logic [7:0] OP_TEXTLEN = 8'd22;

    typedef enum logic [2:0] {
        EV_KEY      = 3'd0,
        EV_PIXEL    = 3'd1,
        EV_ROWSAVED = 3'd2,
        EV_TEXTLEN  = 3'd3,
        EV_CHAR     = 3'd4
    } ev_kind_t;

    typedef enum logic [2:0] {
        ST_OPCODE,
        ST_BTN_KEY,
        ST_BTN_PRESS,
        ST_SCR_ROW,
        ST_SCR_PIX,
        ST_TXT_COUNT,
        ST_TXT_CHAR,
        ST_LEN
    } fstate_t;

    typedef enum logic [2:0] {
        ROLE_KEY,
        ROLE_PRESS,
        ROLE_ROW,
        ROLE_PIXEL,
        ROLE_CHAR,
        ROLE_LEN
    } role_t;

    typedef struct packed {
        role_t            role;
        logic [7:0]       data;
        logic [COL_W-1:0] column;
        logic             last;
    } tag_t;

    typedef struct packed {
        ev_kind_t         kind;
        logic [7:0]       key_code;
        logic [7:0]       press_type;
        logic [7:0]       row_number;
        logic [COL_W-1:0] column;
        logic [7:0]       pixel_value;
        logic [7:0]       length_value;
        logic [7:0]       character;
        logic             last_char;
    } res_t;

endpackage

`default_nettype wire

// ----- sv/cbsd_front.sv -----
// Front end: tracks command position and tags each byte with its role.
`default_nettype none

module cbsd_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   data_byte,
    output logic              tag_valid,
    output cbsd_pkg::tag_t    tag
);
    import cbsd_pkg::*;

    fstate_t          state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [7:0]       total_reg, total_next;
    logic [7:0]       rcvd_reg, rcvd_next;
    logic [7:0]       rcvd_inc;

    assign rcvd_inc = 8'(rcvd_reg + 8'd1);

    // Advance the command position
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        total_next = total_reg;
        rcvd_next  = rcvd_reg;
        unique case (state_reg)
            ST_OPCODE:
            begin
                if (data_byte == OP_BUTTON)
                    state_next = ST_BTN_KEY;
                else if (data_byte == OP_SCREEN)
                    state_next = ST_SCR_ROW;
                else if (data_byte == OP_CONSOLE)
                    state_next = ST_TXT_COUNT;
                else if (data_byte == OP_TEXTLEN)
                    state_next = ST_LEN;
                else
                    state_next = ST_OPCODE;
            end
            ST_BTN_KEY:   state_next = ST_BTN_PRESS;
            ST_BTN_PRESS: state_next = ST_OPCODE;
            ST_SCR_ROW:
            begin
                state_next = ST_SCR_PIX;
                col_next   = '0;
            end
            ST_SCR_PIX:
            begin
                if (col_reg == COL_LAST)
                    state_next = ST_OPCODE;
                else
                    col_next = COL_W'(col_reg + 1'b1);
            end
            ST_TXT_COUNT:
            begin
                total_next = data_byte;
                rcvd_next  = '0;
                state_next = (data_byte == 8'd0) ? ST_OPCODE : ST_TXT_CHAR;
            end
            ST_TXT_CHAR:
            begin
                rcvd_next = rcvd_inc;
                if (rcvd_inc == total_reg)
                    state_next = ST_OPCODE;
            end
            ST_LEN:       state_next = ST_OPCODE;
            default:      state_next = ST_OPCODE;
        endcase
    end

    // Tag the current byte
    always_comb
    begin
        tag_valid  = 1'b1;
        tag.role   = ROLE_KEY;
        tag.data   = data_byte;
        tag.column = col_reg;
        tag.last   = 1'b0;
        unique case (state_reg)
            ST_OPCODE:    tag_valid = 1'b0;
            ST_BTN_KEY:   tag.role  = ROLE_KEY;
            ST_BTN_PRESS: tag.role  = ROLE_PRESS;
            ST_SCR_ROW:   tag.role  = ROLE_ROW;
            ST_SCR_PIX:
            begin
                tag.role = ROLE_PIXEL;
                tag.last = (col_reg == COL_LAST);
            end
            ST_TXT_COUNT: tag_valid = 1'b0;
            ST_TXT_CHAR:
            begin
                tag.role = ROLE_CHAR;
                tag.last = (rcvd_inc == total_reg);
            end
            ST_LEN:       tag.role  = ROLE_LEN;
            default:      tag_valid = 1'b0;
        endcase
    end

    // Update on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_OPCODE;
            col_reg   <= '0;
            total_reg <= '0;
            rcvd_reg  <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            total_reg <= total_next;
            rcvd_reg  <= rcvd_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cbsd_tagq.sv -----
// Two-entry queue of tagged bytes between front and back end.
`default_nettype none

module cbsd_tagq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire cbsd_pkg::tag_t wr_tag,
    output logic                q_full,
    input  wire logic           rd_en,
    output logic                q_empty,
    output cbsd_pkg::tag_t      rd_tag
);
    import cbsd_pkg::*;

    tag_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign rd_tag  = mem_reg[rd_ptr_reg];

    // Track the fill level
    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = 2'(cnt_reg + 2'd1);
        else if (!wr_en && rd_en)
            cnt_next = 2'(cnt_reg - 2'd1);
    end

    // Store a word
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_tag;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cbsd_back.sv -----
// Back end: executes tagged bytes and queues the resulting events.
`default_nettype none

module cbsd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           tq_empty,
    input  wire cbsd_pkg::tag_t tq_tag,
    output logic                tq_pop,
    output logic                out_empty,
    input  wire logic           out_pop,
    output cbsd_pkg::res_t      out_res
);
    import cbsd_pkg::*;

    logic [7:0] held_key_reg;
    logic [7:0] held_row_reg;
    res_t       res;
    logic       res_valid;
    logic       out_push;

    res_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       out_rd;

    assign tq_pop    = !tq_empty && (cnt_reg != 2'd2);
    assign out_push  = tq_pop && res_valid;
    assign out_empty = (cnt_reg == 2'd0);
    assign out_rd    = out_pop && !out_empty;
    assign out_res   = mem_reg[rd_ptr_reg];

    // Form the event of the head word
    always_comb
    begin
        res       = '0;
        res_valid = 1'b1;
        unique case (tq_tag.role)
            ROLE_KEY:   res_valid = 1'b0;
            ROLE_ROW:   res_valid = 1'b0;
            ROLE_PRESS:
            begin
                res.kind       = EV_KEY;
                res.key_code   = held_key_reg;
                res.press_type = tq_tag.data;
            end
            ROLE_PIXEL:
            begin
                res.kind        = tq_tag.last ? EV_ROWSAVED : EV_PIXEL;
                res.row_number  = held_row_reg;
                res.column      = tq_tag.column;
                res.pixel_value = tq_tag.data;
            end
            ROLE_CHAR:
            begin
                res.kind      = EV_CHAR;
                res.character = tq_tag.data;
                res.last_char = tq_tag.last;
            end
            ROLE_LEN:
            begin
                res.kind         = EV_TEXTLEN;
                res.length_value = tq_tag.data;
            end
            default:    res_valid = 1'b0;
        endcase
    end

    // Hold key and row bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_key_reg <= '0;
            held_row_reg <= '0;
        end
        else if (tq_pop)
        begin
            if (tq_tag.role == ROLE_KEY)
                held_key_reg <= tq_tag.data;
            if (tq_tag.role == ROLE_ROW)
                held_row_reg <= tq_tag.data;
        end
    end

    // Track the result queue fill level
    always_comb
    begin
        cnt_next = cnt_reg;
        if (out_push && !out_rd)
            cnt_next = 2'(cnt_reg + 2'd1);
        else if (!out_push && out_rd)
            cnt_next = 2'(cnt_reg - 2'd1);
    end

    // Store a result word
    always_ff @(posedge clk)
    begin
        if (out_push)
            mem_reg[wr_ptr_reg] <= res;
    end

    // Advance result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (out_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (out_rd)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/command_byte_stream_decoder.sv -----
// Command byte stream decoder: turns command bytes into key, pixel and text events.
// One byte is taken per clock while full is low. The front end tags each byte with
// its role in the current command and writes all but opcode and count bytes into a
// two-entry queue; the back end executes one tagged word per cycle, while its output
// has room, into a two-entry result queue. A byte that causes an event is registered
// in the tag queue, then in the result queue, whose head drives the result ports; a
// continuous stream sustains one byte per cycle as long as results are popped at the
// same rate. Only the two queues set the latency; there is no clearing pass after reset.
`default_nettype none

`include "command_byte_stream_decoder_defines.svh"

module command_byte_stream_decoder (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [7:0]                 data_byte,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [2:0]                      event_kind,
    output logic [7:0]                      key_code,
    output logic [7:0]                      press_type,
    output logic [7:0]                      row_number,
    output logic [cbsd_pkg::COL_W-1:0]      column,
    output logic [7:0]                      pixel_value,
    output logic [7:0]                      length_value,
    output logic [7:0]                      character,
    output logic                            last_char
);
    import cbsd_pkg::*;

    logic accept;
    logic tag_valid;
    tag_t front_tag;
    tag_t head_tag;
    logic tq_empty;
    logic tq_pop;
    res_t res;

    assign accept = push && !full;

    cbsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .tag_valid (tag_valid),
        .tag       (front_tag)
    );

    cbsd_tagq u_tagq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && tag_valid),
        .wr_tag  (front_tag),
        .q_full  (full),
        .rd_en   (tq_pop),
        .q_empty (tq_empty),
        .rd_tag  (head_tag)
    );

    cbsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tq_empty  (tq_empty),
        .tq_tag    (head_tag),
        .tq_pop    (tq_pop),
        .out_empty (empty),
        .out_pop   (pop),
        .out_res   (res)
    );

    // Drive result ports from the head of the result queue
    assign event_kind   = res.kind;
    assign key_code     = res.key_code;
    assign press_type   = res.press_type;
    assign row_number   = res.row_number;
    assign column       = res.column;
    assign pixel_value  = res.pixel_value;
    assign length_value = res.length_value;
    assign character    = res.character;
    assign last_char    = res.last_char;

    // Check event consistency
    `CBSD_ASSERT_IMPLY(a_rowsaved_col, !empty && event_kind == EV_ROWSAVED, column == COL_LAST, "row saved off the final column")
    `CBSD_ASSERT_IMPLY(a_pixel_col, !empty && event_kind == EV_PIXEL, column != COL_LAST, "pixel write on the final column")
    `CBSD_ASSERT_IMPLY(a_last_kind, !empty && last_char, event_kind == EV_CHAR, "last mark on a non-character event")
    `CBSD_ASSERT_NEXT(a_hold_head, !empty && !pop, !empty && $stable(event_kind), "waiting result changed")

endmodule

`default_nettype wire

// ----- sim/tb_command_byte_stream_decoder.sv -----
// Self-checking testbench for the command byte stream decoder.
`timescale 1ns / 100ps

module tb_command_byte_stream_decoder;

    import cbsd_pkg::*;

    localparam int OPCODE_COUNT  = 23;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 1000000;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic [7:0]       data_byte = 8'h00;
    logic             pop = 1'b0;
    logic             full;
    logic             empty;
    logic [2:0]       event_kind;
    logic [7:0]       key_code;
    logic [7:0]       press_type;
    logic [7:0]       row_number;
    logic [COL_W-1:0] column;
    logic [7:0]       pixel_value;
    logic [7:0]       length_value;
    logic [7:0]       character;
    logic             last_char;

    // Decoder state as seen by the predictor
    int         cmd_pos = 0;
    logic [7:0] cur_cmd = 8'h00;
    logic [7:0] held_key = 8'h00;
    logic [7:0] held_row = 8'h00;
    logic [7:0] text_total = 8'h00;
    logic [7:0] text_count = 8'h00;

    res_t pending_events[$];
    int   mismatch_count = 0;
    int   kept_bytes = 0;
    int   burst_left = 0;
    int   cycle_count = 0;
    logic hold_request = 1'b0;
    int   rx_mode = 0;
    int   rx_tick = 0;

    command_byte_stream_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .empty        (empty),
        .pop          (pop),
        .event_kind   (event_kind),
        .key_code     (key_code),
        .press_type   (press_type),
        .row_number   (row_number),
        .column       (column),
        .pixel_value  (pixel_value),
        .length_value (length_value),
        .character    (character),
        .last_char    (last_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Advance the decoder state by one byte; return 1 when the byte yields an event
    function automatic bit decode_byte(input logic [7:0] b, output res_t ev);
        ev = '0;
        if (cmd_pos == 0)
        begin
            if (b == OP_BUTTON || b == OP_SCREEN || b == OP_CONSOLE || b == OP_TEXTLEN)
            begin
                cur_cmd = b;
                cmd_pos = 1;
            end
            return 1'b0;
        end
        case (cur_cmd)
            OP_BUTTON:
            begin
                if (cmd_pos == 1)
                begin
                    held_key = b;
                    cmd_pos  = 2;
                    return 1'b0;
                end
                ev.kind       = EV_KEY;
                ev.key_code   = held_key;
                ev.press_type = b;
                cmd_pos       = 0;
                return 1'b1;
            end
            OP_SCREEN:
            begin
                if (cmd_pos == 1)
                begin
                    held_row = b;
                    cmd_pos  = 2;
                    return 1'b0;
                end
                ev.row_number  = held_row;
                ev.column      = COL_W'(cmd_pos - 2);
                ev.pixel_value = b;
                // the final pixel doubles as the row saved event
                if (cmd_pos >= ROW_PIXELS + 1)
                begin
                    ev.kind = EV_ROWSAVED;
                    cmd_pos = 0;
                end
                else
                begin
                    ev.kind = EV_PIXEL;
                    cmd_pos++;
                end
                return 1'b1;
            end
            OP_CONSOLE:
            begin
                if (cmd_pos == 1)
                begin
                    text_total = b;
                    text_count = 8'h00;
                    cmd_pos    = (b == 8'h00) ? 0 : 2;
                    return 1'b0;
                end
                text_count   = text_count + 8'h01;
                ev.kind      = EV_CHAR;
                ev.character = b;
                if (text_count == text_total)
                begin
                    ev.last_char = 1'b1;
                    cmd_pos      = 0;
                end
                return 1'b1;
            end
            OP_TEXTLEN:
            begin
                ev.kind         = EV_TEXTLEN;
                ev.length_value = b;
                cmd_pos         = 0;
                return 1'b1;
            end
            default:
            begin
                cmd_pos = 0;
                return 1'b0;
            end
        endcase
    endfunction

    // Offer one word in bursts with random gaps, wait for acceptance, then predict
    task automatic send_byte(input logic [7:0] b);
        res_t ev;
        int   gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 :
                  ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
            repeat (gap)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        push      <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (full);
        if (!(cmd_pos == 0 && b >= OPCODE_COUNT))
            kept_bytes++;
        if (decode_byte(b, ev))
            pending_events.push_back(ev);
    endtask

    task automatic send_button(input logic [7:0] key, input logic [7:0] press);
        send_byte(OP_BUTTON);
        send_byte(key);
        send_byte(press);
    endtask

    task automatic send_textlen(input logic [7:0] len);
        send_byte(OP_TEXTLEN);
        send_byte(len);
    endtask

    task automatic send_console(input logic [7:0] count);
        send_byte(OP_CONSOLE);
        send_byte(count);
        repeat (count)
            send_byte(8'($urandom()));
    endtask

    // Send a full row; first and last pixels are fixed to the extremes
    task automatic send_screen(input logic [7:0] row);
        send_byte(OP_SCREEN);
        send_byte(row);
        for (int i = 0; i < ROW_PIXELS; i++)
            send_byte((i == 0) ? 8'h00 : (i == ROW_PIXELS - 1) ? 8'hFF : 8'($urandom()));
    endtask

    // Opcodes without a handler, then out-of-range opcodes that get dropped
    task automatic test_empty_opcodes();
        for (int op = 0; op < OPCODE_COUNT; op++)
            if (op != OP_BUTTON && op != OP_SCREEN && op != OP_CONSOLE && op != OP_TEXTLEN)
                send_byte(8'(op));
        send_byte(8'(OPCODE_COUNT));
        send_byte(8'd31);
        send_byte(8'h80);
        send_byte(8'hFF);
    endtask

    task automatic test_button();
        send_button(8'h00, 8'h00);
        send_button(8'hFF, 8'hFF);
    endtask

    task automatic test_text_length();
        send_textlen(8'h00);
        send_textlen(8'hFF);
    endtask

    // Zero-length text ends on its count; one and two characters check the last mark
    task automatic test_console_text();
        send_console(8'd0);
        send_console(8'd1);
        send_console(8'd2);
    endtask

    task automatic test_screen_row();
        send_screen(8'hFF);
    endtask

    // Hold the receiver off while words keep coming so both queues fill up
    task automatic test_receiver_hold();
        hold_request <= 1'b1;
        repeat (40)
            send_textlen(8'($urandom()));
        while (hold_request)
            @(posedge clk);
    endtask

    // Mostly well-formed commands with random content, some dropped opcodes as noise
    task automatic test_random_stream();
        int start;
        int pick;
        int op;
        start = kept_bytes;
        while (kept_bytes - start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                send_button(8'($urandom()), 8'($urandom()));
            else if (pick < 45)
                send_textlen(8'($urandom()));
            else if (pick < 70)
                send_console(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(0, 6)));
            else if (pick < 72)
                send_screen(8'($urandom()));
            else if (pick < 90)
            begin
                op = $urandom_range(0, OPCODE_COUNT - 1);
                if (op == OP_BUTTON || op == OP_SCREEN || op == OP_CONSOLE || op == OP_TEXTLEN)
                    op = 0;
                send_byte(8'(op));
            end
            else
                send_byte(8'($urandom_range(OPCODE_COUNT, 255)));
        end
    endtask

    task automatic check_field(input string fname, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", fname, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Compare each popped word with the oldest prediction and drive pop
    always @(posedge clk)
    begin
        res_t ev;
        if (rst_n && pop && !empty)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected event: event_kind %0d", event_kind);
                mismatch_count++;
            end
            else
            begin
                ev = pending_events.pop_front();
                check_field("event_kind", ev.kind, event_kind);
                check_field("key_code", ev.key_code, key_code);
                check_field("press_type", ev.press_type, press_type);
                check_field("row_number", ev.row_number, row_number);
                check_field("column", ev.column, column);
                check_field("pixel_value", ev.pixel_value, pixel_value);
                check_field("length_value", ev.length_value, length_value);
                check_field("character", ev.character, character);
                check_field("last_char", ev.last_char, last_char);
            end
        end
        if (rx_tick % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        rx_tick++;
        case (rx_mode)
            0:       pop <= !hold_request;
            1:       pop <= !hold_request && ($urandom_range(0, 1) == 1);
            2:       pop <= !hold_request && ($urandom_range(0, 9) == 0);
            default: pop <= !hold_request && (rx_tick % 4 != 0);
        endcase
    end

    // Count out the long receiver stall
    initial
    begin
        forever
        begin
            wait (hold_request);
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_request <= 1'b0;
            @(posedge clk);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_opcodes();
        test_button();
        test_text_length();
        test_console_text();
        test_screen_row();
        test_receiver_hold();
        test_random_stream();
        push <= 1'b0;

        // Drain outstanding events, then let the pipeline settle
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
